// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

   typedef enum logic [2:0] {
      MODE_RELEASED  = 3'd0,
      MODE_PUSHED    = 3'd1,
      MODE_PRESSED   = 3'd2,
      MODE_HELD      = 3'd3,
      MODE_LONG      = 3'd4,
      MODE_DISABLED  = 3'd5,
      MODE_INTERRUPT = 3'd6
   } mode_type;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_FORCE  = 2'd2;

   localparam logic [1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [1:0] CSR_HOLD       = 2'd1;
   localparam logic [1:0] CSR_LONG_PRESS = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [15:0] HOLD_RESET       = 16'd500;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] hold_ms;
      logic [15:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] last_sample_time;
      logic [31:0] press_start_time;
      logic        press_reported;
   } track_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] time_ms;
      logic        pin_level;
      logic [2:0]  new_state;
   } item_type;

endpackage

`default_nettype wire

// ===== src/bpc_csr.sv =====
// ----------------------------------------------------------------------------
// Button press classifier configuration registers
// Holds the debounce, hold and long-press thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [1:0]     csr_index,
   input  wire logic [15:0]    csr_wdata,
   output bpc_pkg::cfg_type    cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.hold_ms       <= HOLD_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms   <= csr_wdata;
            CSR_HOLD:       cfg_ff.hold_ms       <= csr_wdata;
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/bpc_step.sv =====
// ----------------------------------------------------------------------------
// Button press classifier step logic
// Computes the next tracking state and the reported state for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_step (
   input  wire bpc_pkg::track_type  cur,
   input  wire bpc_pkg::cfg_type    cfg,
   input  wire bpc_pkg::item_type   item,
   output bpc_pkg::track_type       nxt,
   output bpc_pkg::mode_type        reply
);
   import bpc_pkg::*;

   logic [31:0] since_last;
   logic [31:0] press_age;
   logic        sample_ok;
   logic        report_once;

   assign since_last  = item.time_ms - cur.last_sample_time;
   assign press_age   = item.time_ms - cur.press_start_time;
   assign sample_ok   = since_last > {16'd0, cfg.debounce_ms};
   assign report_once = (cur.mode == MODE_PRESSED) || (cur.mode == MODE_LONG);

   always_comb begin
      nxt = cur;
      case (item.cmd)
         CMD_SAMPLE: begin
            if (sample_ok) begin
               nxt.last_sample_time = item.time_ms;
               if (!item.pin_level) begin
                  unique case (cur.mode) inside
                     MODE_LONG: nxt.mode = MODE_DISABLED;
                     MODE_DISABLED: ;
                     MODE_RELEASED, MODE_INTERRUPT: begin
                        nxt.press_start_time = item.time_ms;
                        nxt.mode             = MODE_PUSHED;
                     end
                     default: begin
                        if (press_age > {16'd0, cfg.hold_ms}) begin
                           if (cur.mode == MODE_PUSHED) begin
                              nxt.mode = MODE_HELD;
                           end
                           if (press_age > {16'd0, cfg.long_press_ms}) begin
                              nxt.mode = MODE_LONG;
                           end
                        end
                     end
                  endcase
               end else if (cur.mode == MODE_PUSHED) begin
                  nxt.mode = MODE_PRESSED;
               end else begin
                  nxt.mode           = MODE_RELEASED;
                  nxt.press_reported = 1'b0;
               end
            end
         end
         CMD_READ: begin
            if (report_once) begin
               nxt.press_reported = 1'b1;
            end
         end
         CMD_FORCE: begin
            if (item.new_state <= 3'(MODE_INTERRUPT)) begin
               nxt.mode = mode_type'(item.new_state);
            end
         end
         default: ;
      endcase
   end

   // A finished press is reported once; later reads see pushed.
   always_comb begin
      if (item.cmd == CMD_READ) begin
         if (report_once && cur.press_reported) begin
            reply = MODE_PUSHED;
         end else begin
            reply = cur.mode;
         end
      end else begin
         reply = nxt.mode;
      end
   end

endmodule

`default_nettype wire

// ===== src/button_press_classifier_unit.sv =====
// An item moves from the input register to the result register and rsp_valid.
// Throughput: one item per cycle unless the result stalls. The tracking state
// is updated in the single step between the input and result registers.
// A stalled result holds the result register and backs up the input register.
// Synchronous reset returns the button to released, clears the timestamps
// and the report flag, and restores the default thresholds.
// ----------------------------------------------------------------------------
// Button press classifier top level
// Debounced active-low push button classifier with a one-shot press report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [31:0]  req_time_ms,
   input  wire logic         req_pin_level,
   input  wire logic [2:0]   req_new_state,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_reported_state
);
   import bpc_pkg::*;

   cfg_type   cfg;
   item_type  item_ff;
   logic      item_vld_ff;
   track_type track_ff;
   track_type track_in;
   mode_type  reply_in;
   logic      rsp_vld_ff;
   mode_type  rsp_state_ff;
   logic      rsp_load;
   logic      req_take;

   assign rsp_load  = !rsp_vld_ff || !rsp_stall;
   assign req_stall = item_vld_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_step u_step (
      .cur   (track_ff),
      .cfg   (cfg),
      .item  (item_ff),
      .nxt   (track_in),
      .reply (reply_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_take) begin
         item_vld_ff <= 1'b1;
      end else if (rsp_load) begin
         item_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd       <= req_cmd;
         item_ff.time_ms   <= req_time_ms;
         item_ff.pin_level <= req_pin_level;
         item_ff.new_state <= req_new_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff.mode             <= MODE_RELEASED;
         track_ff.last_sample_time <= 32'd0;
         track_ff.press_start_time <= 32'd0;
         track_ff.press_reported   <= 1'b0;
         rsp_vld_ff                <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= item_vld_ff;
         if (item_vld_ff) begin
            track_ff <= track_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && item_vld_ff) begin
         rsp_state_ff <= reply_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_reported_state = rsp_state_ff;

endmodule

`default_nettype wire

// ===== src/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// Button press classifier checker
// Port-level checks on the result channel and on input flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_reported_state
);
   import bpc_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reported_state))
      else $error("Stalled result changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reported_state <= 3'(MODE_INTERRUPT))
      else $error("Reported state out of range.");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("Input stalled while the result stage can move.");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_reported_state (rsp_reported_state)
);

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives sample, read and force items through the valid/stall channels with
// random gaps and stalls and predicts every reported state cycle-free. The
// expected states wait in order and each accepted result is checked against
// the oldest one. The thresholds are rewritten between phases while the unit
// is idle, from all zeros to all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bpc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [2:0] STATE_INVALID = 3'd7;
   localparam logic PIN_DOWN = 1'b0;
   localparam logic PIN_UP = 1'b1;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 272;
   localparam int CYCLE_LIMIT = 200000;

   class press_tracker;
      logic [15:0] debounce_ms;
      logic [15:0] hold_ms;
      logic [15:0] long_press_ms;
      mode_type mode;
      logic [31:0] last_sample;
      logic [31:0] press_start;
      logic reported;
      mode_type expected_states[$];
      int unsigned errors;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         hold_ms = HOLD_RESET;
         long_press_ms = LONG_PRESS_RESET;
         mode = MODE_RELEASED;
         last_sample = '0;
         press_start = '0;
         reported = 1'b0;
         errors = 0;
      endfunction

      function void write_threshold(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_DEBOUNCE: debounce_ms = value;
            CSR_HOLD: hold_ms = value;
            CSR_LONG_PRESS: long_press_ms = value;
            default: ;
         endcase
      endfunction

      function void sample(logic [31:0] stamp, logic pin);
         logic [31:0] since;
         logic [31:0] held_for;
         since = stamp - last_sample;
         if (since <= {16'd0, debounce_ms}) return;
         last_sample = stamp;
         if (pin == PIN_DOWN) begin
            if (mode == MODE_LONG) begin
               mode = MODE_DISABLED;
            end else if (mode == MODE_RELEASED || mode == MODE_INTERRUPT) begin
               press_start = stamp;
               mode = MODE_PUSHED;
            end else if (mode != MODE_DISABLED) begin
               held_for = stamp - press_start;
               if (held_for > {16'd0, hold_ms}) begin
                  if (mode == MODE_PUSHED) mode = MODE_HELD;
                  if (held_for > {16'd0, long_press_ms}) mode = MODE_LONG;
               end
            end
         end else if (mode == MODE_PUSHED) begin
            mode = MODE_PRESSED;
         end else begin
            mode = MODE_RELEASED;
            reported = 1'b0;
         end
      endfunction

      function void note_item(item_type it);
         mode_type reply;
         reply = mode;
         case (it.cmd)
            CMD_SAMPLE: begin
               sample(it.time_ms, it.pin_level);
               reply = mode;
            end
            CMD_READ: begin
               if ((mode == MODE_PRESSED || mode == MODE_LONG) && reported) begin
                  reply = MODE_PUSHED;
               end else begin
                  if (mode == MODE_PRESSED || mode == MODE_LONG) reported = 1'b1;
                  reply = mode;
               end
            end
            CMD_FORCE: begin
               if (it.new_state != STATE_INVALID) mode = mode_type'(it.new_state);
               reply = mode;
            end
            default: ;
         endcase
         expected_states.push_back(reply);
      endfunction

      function void check_result(logic [2:0] got);
         mode_type want;
         if (expected_states.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: state %0d", got);
            return;
         end
         want = expected_states.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("state mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_DEBOUNCE;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_SAMPLE;
   logic [31:0] req_time_ms = '0;
   logic req_pin_level = PIN_UP;
   logic [2:0] req_new_state = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_reported_state;

   press_tracker sb;
   int send_idle_pct = 23;
   int recv_idle_pct = 48;
   logic hold_off_req = 1'b0;
   logic hold_off_taken = 1'b0;
   int hold_off_left = 0;
   int cycle_count = 0;
   logic [31:0] cur_time;
   logic cur_pin = PIN_UP;
   int step_max;

   logic [15:0] phase_debounce[PHASES] = '{16'd0, 16'd10, 16'hFFFF, 16'd5, 16'd0, 16'd0};
   logic [15:0] phase_hold[PHASES] = '{16'd0, 16'd60, 16'hFFFF, 16'd40, 16'd0, 16'hFFFF};
   logic [15:0] phase_long[PHASES] = '{16'd0, 16'd250, 16'hFFFF, 16'd30, 16'd0, 16'd1};
   int phase_step[PHASES] = '{4, 60, 200000, 30, 300, 30000};

   button_press_classifier_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_time_ms(req_time_ms),
      .req_pin_level(req_pin_level),
      .req_new_state(req_new_state),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_reported_state(rsp_reported_state)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_req && !hold_off_taken) begin
         hold_off_taken <= 1'b1;
         hold_off_left <= 80;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_reported_state);
   end

   function automatic item_type make_item(logic [1:0] cmd, logic [31:0] stamp, logic pin,
                                          logic [2:0] state);
      item_type it;
      it.cmd = cmd;
      it.time_ms = stamp;
      it.pin_level = pin;
      it.new_state = state;
      return it;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int pick;
      pick = $urandom_range(99);
      it = make_item(CMD_SAMPLE, $urandom(), 1'($urandom_range(1)), 3'($urandom_range(7)));
      if (pick < 62) begin
         if ($urandom_range(99) < 15) cur_pin = ~cur_pin;
         if ($urandom_range(9) == 0)
            cur_time = cur_time + sb.debounce_ms + $urandom_range(1);
         else
            cur_time = cur_time + $urandom_range(step_max);
         it.time_ms = cur_time;
         it.pin_level = cur_pin;
      end else if (pick < 82) begin
         it.cmd = CMD_READ;
      end else if (pick < 90) begin
         it.cmd = CMD_FORCE;
      end else if (pick < 93) begin
         it.cmd = CMD_UNUSED;
      end else if (pick < 96) begin
         cur_time = 32'hFFFF_FFFF - $urandom_range(3 * step_max);
      end
      return it;
   endfunction

   task automatic send_item(input item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_time_ms <= it.time_ms;
      req_pin_level <= it.pin_level;
      req_new_state <= it.new_state;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [15:0] debounce, input logic [15:0] hold,
                                 input logic [15:0] long_press);
      logic [15:0] junk;
      junk = 16'($urandom());
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= debounce;
      @(posedge clock);
      sb.write_threshold(CSR_DEBOUNCE, debounce);
      csr_index <= CSR_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      sb.write_threshold(CSR_HOLD, hold);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= long_press;
      @(posedge clock);
      sb.write_threshold(CSR_LONG_PRESS, long_press);
      csr_index <= CSR_UNUSED;
      csr_wdata <= junk;
      @(posedge clock);
      sb.write_threshold(CSR_UNUSED, junk);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd50, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd51, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd200, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd552, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2052, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2200, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2300, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2400, PIN_UP, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2500, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2600, PIN_UP, 3'd0));
      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'd2700, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_FORCE, 32'd0, PIN_UP, MODE_INTERRUPT));
      send_item(make_item(CMD_FORCE, 32'hFFFF_FFFF, PIN_UP, STATE_INVALID));
      send_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, PIN_DOWN, STATE_INVALID));
      send_item(make_item(CMD_SAMPLE, 32'hFFFF_FFF0, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'h0000_0300, PIN_DOWN, 3'd0));
      send_item(make_item(CMD_SAMPLE, 32'hFFFF_FFFF, PIN_UP, 3'd0));
      send_item(make_item(CMD_FORCE, 32'd0, PIN_UP, MODE_DISABLED));
      send_item(make_item(CMD_READ, 32'd0, PIN_UP, 3'd0));
      send_item(make_item(CMD_FORCE, 32'd0, PIN_UP, MODE_RELEASED));

      cur_time = $urandom();
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 48 : 0;
         recv_idle_pct <= (phase < 2) ? 48 : (phase < 4) ? 23 : 0;
         step_max = phase_step[phase];
         if (phase == 4)
            set_thresholds(16'($urandom_range(255)), 16'($urandom_range(255)),
                           16'($urandom_range(255)));
         else
            set_thresholds(phase_debounce[phase], phase_hold[phase], phase_long[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 100) hold_off_req <= 1'b1;
            if (phase == 3 && n == 136) drain();
            send_item(random_item());
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/bpc_pkg.sv
src/bpc_csr.sv
src/bpc_step.sv
src/button_press_classifier_unit.sv
src/bpc_checker.sv
test/tb.sv
